/* design/first_free_slot_owner_table_assert.svh */
// Assertion macros shared by the checker files of the slot owner table.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FIRST_FREE_SLOT_OWNER_TABLE_ASSERT_SVH
`define FIRST_FREE_SLOT_OWNER_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFSOT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFSOT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ffsot_pkg.sv */
// Package for the slot owner table: operation and status codes, the
// controller state type, the map control struct and the first-zero search.
// No dependencies.
`default_nettype none

package ffsot_pkg;

  // The occupancy map is stored as words of this many slot bits.
  localparam int MAP_W     = 32;
  localparam int MAP_BIT_W = 5;

  localparam int STATUS_W = 3;

  localparam logic [1:0] OP_RESERVE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_OWNER = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_TABLE  = 3'd4;

  typedef enum logic {
    S_IDLE,
    S_WORK
  } fsm_state_t;

  typedef struct packed {
    logic rd;       // read a map word this cycle
    logic rd_free;  // read the lowest word that still has a free slot
    logic wr;       // write back the word that was read last
    logic clear;    // start a clearing pass over the whole map
  } map_ctl_t;

  // Index of the lowest zero bit of a map word.
  function automatic logic [MAP_BIT_W-1:0] first_zero(input logic [MAP_W-1:0] w);
    logic [MAP_BIT_W-1:0] idx;
    idx = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = MAP_BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* design/ffsot_ifs.sv */
// Handshake interfaces of the slot owner table: request, result and
// capacity write channels. Depends on nothing.
`default_nettype none

interface ffsot_in_if #(parameter int CNT_W = 11, parameter int OWNER_BITS = 31);
  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  logic [OWNER_BITS-1:0] owner_id;
  logic [CNT_W-1:0]      slot_number;

  modport source (output valid, output op, output owner_id, output slot_number,
                  input ready);
  modport sink   (input valid, input op, input owner_id, input slot_number,
                  output ready);
endinterface

interface ffsot_out_if #(parameter int CNT_W = 11, parameter int OWNER_BITS = 31);
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [CNT_W-1:0]      granted_slot;
  logic [OWNER_BITS-1:0] slot_owner;
  logic [CNT_W-1:0]      free_slots;
  logic [CNT_W-1:0]      used_slots;

  modport source (output valid, output status, output granted_slot,
                  output slot_owner, output free_slots, output used_slots,
                  input ready);
  modport sink   (input valid, input status, input granted_slot,
                  input slot_owner, input free_slots, input used_slots,
                  output ready);
endinterface

interface ffsot_cfg_if #(parameter int CNT_W = 11);
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

/* design/ffsot_map.sv */
// Occupancy map of the slot owner table: one bit per slot in a word memory,
// a full-word summary and the clearing pass. Depends on ffsot_pkg.
`default_nettype none

module ffsot_map #(
  parameter int MAP_WORDS = 32,
  parameter int WIDX_W    = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ffsot_pkg::map_ctl_t          ctl,
  input  logic [WIDX_W-1:0]            rd_word,
  input  logic [ffsot_pkg::MAP_W-1:0]  wr_data,
  output logic                         busy,
  output logic [ffsot_pkg::MAP_W-1:0]  word_q,
  output logic [WIDX_W-1:0]            widx_q
);
  import ffsot_pkg::*;

  logic [MAP_W-1:0]     map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] summary_r;
  logic                 clr_r;
  logic [WIDX_W-1:0]    clr_cnt_r;
  logic [WIDX_W-1:0]    free_word;
  logic [WIDX_W-1:0]    rd_addr;

  // Lowest word whose summary bit says it still has a free slot.
  always_comb begin
    free_word = '0;
    for (int i = MAP_WORDS - 1; i >= 0; i--) begin
      if (!summary_r[i]) begin
        free_word = WIDX_W'(i);
      end
    end
  end

  assign rd_addr = ctl.rd_free ? free_word : rd_word;
  assign busy    = clr_r;

  // Writes other than clears go to the word read last, so need no forwarding.
  always_ff @(posedge clk) begin
    if (clr_r) begin
      map_mem[clr_cnt_r] <= '0;
    end else if (ctl.wr) begin
      map_mem[widx_q] <= wr_data;
    end
    if (ctl.rd) begin
      word_q <= map_mem[rd_addr];
      widx_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b0;
      clr_cnt_r <= '0;
      summary_r <= '0;
    end else if (ctl.clear) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      summary_r <= '0;
    end else begin
      if (clr_r) begin
        if (clr_cnt_r == WIDX_W'(MAP_WORDS - 1)) begin
          clr_r <= 1'b0;
        end else begin
          clr_cnt_r <= clr_cnt_r + WIDX_W'(1);
        end
      end
      if (ctl.wr) begin
        summary_r[widx_q] <= &wr_data;
      end
    end
  end

endmodule

`default_nettype wire

/* design/first_free_slot_owner_table.sv */
// Top level of the slot owner table: request/result handshakes, owner memory,
// counters and controller. Depends on ffsot_pkg, ffsot_ifs and ffsot_map.
//
// Usage. A capacity word on cfg_ch creates a new, empty table of that many
// slots (values above SLOTS saturate to SLOTS, zero means no table). A request
// word on in_ch is a reserve, release or query; every request gives exactly one
// result word on out_ch with a status, the granted slot, the slot owner and the
// free and used counts after the operation.
// Timing: when a request is accepted, the occupancy map word and the owner
// memory entry are read into registers; in the work state that follows the
// result is decided and registered when the output register is free or
// draining. A new request is taken only after the last one has been loaded
// into the output register.
// Reset clears the capacity to zero, so every request answers "no table".
// Each capacity write starts a clearing pass that zeroes the occupancy map
// words in turn; in_ch.ready stays low for that time. cfg_ch.ready is
// always high.
// When the receiver stalls, the result word holds on out_ch; one more request
// may be accepted meanwhile, and its work waits until the output register frees.
`default_nettype none

module first_free_slot_owner_table #(
  parameter int SLOTS      = 1024,
  parameter int OWNER_BITS = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  ffsot_in_if.sink     in_ch,
  ffsot_out_if.source  out_ch,
  ffsot_cfg_if.sink    cfg_ch
);
  import ffsot_pkg::*;

  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int SIDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAP_WORDS = (SLOTS + MAP_W - 1) / MAP_W;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int XI_W      = WIDX_W + MAP_BIT_W;

  // Controller state and counters.
  fsm_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  capacity_r, capacity_nxt;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Request held for the work state.
  logic [1:0]            op_r;
  logic [OWNER_BITS-1:0] owner_id_r;
  logic                  slot_ok_r;
  logic [XI_W-1:0]       sidx_r;

  // Result payload registers.
  logic [STATUS_W-1:0]   status_r;
  logic [CNT_W-1:0]      granted_r;
  logic [OWNER_BITS-1:0] slot_owner_r;

  // Owner memory; an entry is meaningful only while its map bit is set.
  logic [OWNER_BITS-1:0] owner_mem [SLOTS];
  logic [OWNER_BITS-1:0] owner_q_r;

  logic                   in_ready;
  logic                   in_acc;
  logic                   cfg_acc;
  logic                   out_load;
  logic [CNT_W-1:0]       slot_m1;
  logic [CNT_W+XI_W-1:0]  slot_pad;
  logic [XI_W-1:0]        in_xidx;
  logic                   in_slot_ok;
  logic [CNT_W-1:0]       cap_sat;

  map_ctl_t               map_ctl;
  logic                   map_busy;
  logic [MAP_W-1:0]       map_word;
  logic [WIDX_W-1:0]      map_widx;
  logic [MAP_W-1:0]       map_wdata;
  logic                   map_wr_req;
  logic                   own_wr_req;

  logic [MAP_BIT_W-1:0]   res_bit;
  logic [XI_W-1:0]        res_xidx;
  logic [CNT_W+XI_W-1:0]  res_pad;
  logic                   hit_bit;
  logic [STATUS_W-1:0]    status_nxt;
  logic [CNT_W-1:0]       granted_nxt;
  logic [OWNER_BITS-1:0]  slot_owner_nxt;

  assign in_acc  = in_ch.valid && in_ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  // Slot numbers count from 1; the zero-based index is split into map word
  // and bit position.
  assign slot_m1    = in_ch.slot_number - CNT_W'(1);
  assign slot_pad   = {{XI_W{1'b0}}, slot_m1};
  assign in_xidx    = slot_pad[XI_W-1:0];
  assign in_slot_ok = (in_ch.slot_number != '0) && (in_ch.slot_number <= capacity_r);

  assign cap_sat = (cfg_ch.capacity > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cfg_ch.capacity;

  assign map_ctl.rd      = in_acc;
  assign map_ctl.rd_free = (in_ch.op == OP_RESERVE);
  assign map_ctl.wr      = map_wr_req && out_load;
  assign map_ctl.clear   = cfg_acc;

  ffsot_map #(
    .MAP_WORDS (MAP_WORDS),
    .WIDX_W    (WIDX_W)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (map_ctl),
    .rd_word (in_xidx[XI_W-1:MAP_BIT_W]),
    .wr_data (map_wdata),
    .busy    (map_busy),
    .word_q  (map_word),
    .widx_q  (map_widx)
  );

  // Next state of the controller.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Controller outputs: take a request only when idle and the map is not
  // being cleared; finish one when the output register is free or draining.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = !map_busy;
      end
      S_WORK: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Work state: the map word and owner entry are in hand; decide the result
  // and the write back.
  assign res_bit  = first_zero(map_word);
  assign res_xidx = {map_widx, res_bit};
  assign res_pad  = {{CNT_W{1'b0}}, res_xidx};
  assign hit_bit  = map_word[sidx_r[MAP_BIT_W-1:0]];

  always_comb begin
    status_nxt     = ST_OK;
    granted_nxt    = '0;
    slot_owner_nxt = '0;
    free_nxt       = free_r;
    used_nxt       = used_r;
    map_wdata      = map_word;
    map_wr_req     = 1'b0;
    own_wr_req     = 1'b0;
    if (capacity_r == '0) begin
      status_nxt = ST_NO_TABLE;
    end else begin
      case (op_r)
        OP_RESERVE: begin
          if (owner_id_r == '0) begin
            status_nxt = ST_BAD_OWNER;
          end else if (free_r == '0) begin
            status_nxt = ST_FULL;
          end else begin
            map_wdata   = map_word | (MAP_W'(1) << res_bit);
            map_wr_req  = 1'b1;
            own_wr_req  = 1'b1;
            granted_nxt = res_pad[CNT_W-1:0] + CNT_W'(1);
            free_nxt    = free_r - CNT_W'(1);
            used_nxt    = used_r + CNT_W'(1);
          end
        end
        OP_RELEASE: begin
          if (!slot_ok_r) begin
            status_nxt = ST_BAD_SLOT;
          end else if (hit_bit) begin
            // Releasing a free slot changes nothing and reports owner zero.
            slot_owner_nxt = owner_q_r;
            map_wdata      = map_word & ~(MAP_W'(1) << sidx_r[MAP_BIT_W-1:0]);
            map_wr_req     = 1'b1;
            free_nxt       = free_r + CNT_W'(1);
            used_nxt       = used_r - CNT_W'(1);
          end
        end
        OP_QUERY: begin
          if (!slot_ok_r) begin
            status_nxt = ST_BAD_SLOT;
          end else if (hit_bit) begin
            slot_owner_nxt = owner_q_r;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    capacity_nxt  = capacity_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
    if (cfg_acc) begin
      capacity_nxt = cap_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      capacity_r  <= '0;
      free_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      capacity_r  <= capacity_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_acc) begin
        free_r <= cap_sat;
        used_r <= '0;
      end else if (out_load) begin
        free_r <= free_nxt;
        used_r <= used_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r       <= in_ch.op;
      owner_id_r <= in_ch.owner_id;
      slot_ok_r  <= in_slot_ok;
      sidx_r     <= in_xidx;
    end
    if (out_load) begin
      status_r     <= status_nxt;
      granted_r    <= granted_nxt;
      slot_owner_r <= slot_owner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      owner_q_r <= owner_mem[in_xidx[SIDX_W-1:0]];
    end
    if (own_wr_req && out_load) begin
      owner_mem[res_xidx[SIDX_W-1:0]] <= owner_id_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.granted_slot = granted_r;
  assign out_ch.slot_owner   = slot_owner_r;
  // The counters only move when a new result is loaded or the table is
  // rebuilt, so they hold under a stalled result unless capacity is written.
  assign out_ch.free_slots   = free_r;
  assign out_ch.used_slots   = used_r;

endmodule

`default_nettype wire

/* design/ffsot_checker.sv */
// Port-level checker for the slot owner table and its bind statement.
// Depends on ffsot_pkg and first_free_slot_owner_table_assert.svh.
`default_nettype none

`include "first_free_slot_owner_table_assert.svh"

module ffsot_checker #(
  parameter int SLOTS      = 1024,
  parameter int CNT_W      = 11,
  parameter int OWNER_BITS = 31
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [2:0]            status,
  input logic [CNT_W-1:0]      granted_slot,
  input logic [OWNER_BITS-1:0] slot_owner,
  input logic [CNT_W-1:0]      free_slots,
  input logic [CNT_W-1:0]      used_slots,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CNT_W-1:0]      cfg_capacity
);
  import ffsot_pkg::*;

  logic [CNT_W-1:0] cap_seen_r;

  // Capacity as the table saw it at the last write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_seen_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cap_seen_r <= (cfg_capacity > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cfg_capacity;
    end
  end

  `FFSOT_ASSERT_NEXT(a_out_hold, (out_valid && !out_ready), (out_valid && $stable(status) && $stable(granted_slot) && $stable(slot_owner) && $stable(free_slots) && $stable(used_slots)), "stalled result changed")
  `FFSOT_ASSERT_NOW(a_count_sum, out_valid, (({1'b0, free_slots} + {1'b0, used_slots}) == {1'b0, cap_seen_r}), "free and used counts do not add up to capacity")
  `FFSOT_ASSERT_NOW(a_no_table, (out_valid && status == ST_NO_TABLE), (free_slots == '0 && used_slots == '0 && granted_slot == '0 && slot_owner == '0), "no-table result carries nonzero fields")
  `FFSOT_ASSERT_NEXT(a_one_at_a_time, (in_valid && in_ready), (!in_ready), "request accepted in back-to-back cycles")
  `FFSOT_ASSERT_NEXT(a_clear_blocks, (cfg_valid && cfg_ready), (!in_ready), "request accepted during map clearing")

endmodule

bind first_free_slot_owner_table ffsot_checker #(
  .SLOTS      (SLOTS),
  .CNT_W      (CNT_W),
  .OWNER_BITS (OWNER_BITS)
) u_ffsot_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .granted_slot (out_ch.granted_slot),
  .slot_owner   (out_ch.slot_owner),
  .free_slots   (out_ch.free_slots),
  .used_slots   (out_ch.used_slots),
  .cfg_valid    (cfg_ch.valid),
  .cfg_ready    (cfg_ch.ready),
  .cfg_capacity (cfg_ch.capacity)
);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for first_free_slot_owner_table. Drives request, result and capacity words
// through the ffsot interfaces and predicts every result from its own copy of the slot table.
// Depends on ffsot_pkg, ffsot_ifs and the design top level.

module testbench;
  import ffsot_pkg::*;

  localparam int SLOTS      = 1024;
  localparam int CNT_W      = 11;
  localparam int OWNER_BITS = 31;

  // Op code 3 has no meaning in the block; it must be answered as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [OWNER_BITS-1:0] OWNER_MAX = '1;

  // Cycles without any accepted word before the run is declared hung. The
  // longest legal quiet stretch is the long receiver stall plus a clearing pass.
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_STALL  = 60;
  localparam int DRAIN_PAUSE = 8;

  typedef struct {
    logic [2:0]            status;
    logic [CNT_W-1:0]      granted;
    logic [OWNER_BITS-1:0] owner;
    logic [CNT_W-1:0]      free_cnt;
    logic [CNT_W-1:0]      used_cnt;
  } slot_result_t;

  // Shadow copy of the slot table. Each accepted request is applied to it at
  // once, and the result it should produce waits in a queue until the block
  // delivers its own.
  class slot_table_tracker;
    logic [OWNER_BITS-1:0] owners [SLOTS];
    int unsigned           capacity;
    int unsigned           free_total;
    int unsigned           used_total;
    slot_result_t          expected_results[$];
    int                    failures;

    function new();
      failures = 0;
      set_capacity('0);
    endfunction

    // A capacity write builds a fresh, empty table; oversized values saturate.
    function void set_capacity(input logic [CNT_W-1:0] word);
      capacity = (word > SLOTS) ? SLOTS : word;
      foreach (owners[i]) owners[i] = '0;
      free_total = capacity;
      used_total = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(input logic [1:0] op, input logic [OWNER_BITS-1:0] owner,
                               input logic [CNT_W-1:0] slot);
      slot_result_t r;
      int           i;
      bit           slot_valid;
      r.status   = ST_OK;
      r.granted  = '0;
      r.owner    = '0;
      slot_valid = (slot >= 1) && (slot <= capacity);
      if (capacity == 0) begin
        r.status = ST_NO_TABLE;
      end else if (op == OP_RESERVE) begin
        // The owner id is checked before the table is checked for room.
        if (owner == '0) begin
          r.status = ST_BAD_OWNER;
        end else if (free_total == 0) begin
          r.status = ST_FULL;
        end else begin
          i = 0;
          while (owners[i] != '0) i++;
          owners[i] = owner;
          free_total--;
          used_total++;
          r.granted = CNT_W'(i + 1);
        end
      end else if (op == OP_RELEASE || op == OP_QUERY) begin
        if (!slot_valid) begin
          r.status = ST_BAD_SLOT;
        end else begin
          r.owner = owners[slot - 1];
          // Releasing a slot that is already free leaves the counts alone.
          if (op == OP_RELEASE && r.owner != '0) begin
            owners[slot - 1] = '0;
            used_total--;
            free_total++;
          end
        end
      end
      r.free_cnt = CNT_W'(free_total);
      r.used_cnt = CNT_W'(used_total);
      expected_results.push_back(r);
    endfunction

    function void compare_field(input string name, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(input slot_result_t got);
      slot_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result word with nothing expected, status %0d slot %0d owner %0d",
                 $time, got.status, got.granted, got.owner);
        failures++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("granted_slot", want.granted, got.granted);
        compare_field("slot_owner", want.owner, got.owner);
        compare_field("free_slots", want.free_cnt, got.free_cnt);
        compare_field("used_slots", want.used_cnt, got.used_cnt);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ffsot_in_if  #(.CNT_W(CNT_W), .OWNER_BITS(OWNER_BITS)) in_ch ();
  ffsot_out_if #(.CNT_W(CNT_W), .OWNER_BITS(OWNER_BITS)) out_ch ();
  ffsot_cfg_if #(.CNT_W(CNT_W))                          cfg_ch ();

  first_free_slot_owner_table #(
    .SLOTS(SLOTS),
    .OWNER_BITS(OWNER_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  slot_table_tracker tracker;

  // When calm is set, neither side inserts idle cycles any more.
  bit calm;
  // The stimulus raises this flag once to ask the result side for one long stall.
  bit stall_request;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Wait until every expected result has come back. The request valid is
  // dropped first so that the last word is not taken a second time.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Capacity writes happen only when the block is idle. Every request has a
  // result, so an empty queue plus a short pause means nothing is in flight.
  task automatic write_capacity(input logic [CNT_W-1:0] word);
    wait_drained();
    repeat (DRAIN_PAUSE) @(posedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= word;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.set_capacity(word);
    cfg_ch.valid <= 1'b0;
  endtask

  // Offer one request word and hold it until the block takes it. Valid stays
  // high afterwards so that back-to-back words need no extra cycle.
  task automatic send_request(input logic [1:0] op, input logic [OWNER_BITS-1:0] owner,
                              input logic [CNT_W-1:0] slot);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.owner_id    <= owner;
    in_ch.slot_number <= slot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_request(op, owner, slot);
  endtask

  // Owner ids: mostly random over all 31 bits, with zero, the maximum and
  // small values mixed in.
  function automatic logic [OWNER_BITS-1:0] pick_owner();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 7) return OWNER_MAX;
    if (r < 20) return OWNER_BITS'($urandom_range(1, 15));
    return OWNER_BITS'($urandom());
  endfunction

  // Slot numbers: mostly inside the table, sometimes just outside it on
  // either end, and sometimes anywhere in the 11-bit range.
  function automatic logic [CNT_W-1:0] pick_slot(input int cap);
    int r;
    r = $urandom_range(0, 99);
    if (cap > 0 && r < 85) return CNT_W'($urandom_range(1, cap));
    if (r < 90) return '0;
    if (r < 95) return CNT_W'(cap + 1);
    return CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
  endfunction

  // One random phase: a fresh table of the given capacity, then a mix of
  // operations weighted toward reserves by reserve_pct. The stall and pause
  // points are item numbers within the phase, or -1 for none.
  task automatic run_phase(input logic [CNT_W-1:0] cap_word, input int items,
                           input int reserve_pct, input int stall_at, input int pause_at);
    int         cap;
    int         r;
    logic [1:0] op;
    cap = (cap_word > SLOTS) ? SLOTS : cap_word;
    write_capacity(cap_word);
    for (int n = 0; n < items; n++) begin
      if (n == stall_at) stall_request = 1'b1;
      if (n == pause_at) wait_drained();
      r = $urandom_range(0, 99);
      if (r < reserve_pct) begin
        op = OP_RESERVE;
      end else if (r >= 97) begin
        op = OP_UNUSED;
      end else begin
        op = ($urandom_range(0, 1) == 0) ? OP_RELEASE : OP_QUERY;
      end
      send_request(op, pick_owner(), pick_slot(cap));
    end
  endtask

  // Result side: check every accepted word, and decide the ready level for the
  // next cycle. Ready drops in short random bursts, and once for a long stretch
  // while the sender keeps going so that the block backs up.
  initial begin : result_sink
    bit   stall_done;
    slot_result_t got;
    stall_done   = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.status   = out_ch.status;
        got.granted  = out_ch.granted_slot;
        got.owner    = out_ch.slot_owner;
        got.free_cnt = out_ch.free_slots;
        got.used_cnt = out_ch.used_slots;
        tracker.check_result(got);
      end
      if (stall_request && !stall_done) begin
        stall_done   = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= rst_n;
      end
    end
  end

  // The run is considered hung when no word moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    tracker       = new();
    calm          = 1'b0;
    stall_request = 1'b0;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_RESERVE;
    in_ch.owner_id     <= '0;
    in_ch.slot_number  <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.capacity    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Right after reset there is no table, so every operation must say so.
    send_request(OP_RESERVE, 31'd5, 11'd0);
    send_request(OP_RELEASE, 31'd0, 11'd1);
    send_request(OP_QUERY, 31'd0, 11'd1);
    send_request(OP_UNUSED, OWNER_MAX, 11'd2047);

    // A three-slot table: bad owner, fill to full, out-of-range slots on both
    // ends, releasing a slot twice, and a reserve that reuses the freed hole.
    write_capacity(11'd3);
    send_request(OP_RESERVE, 31'd0, 11'd0);
    send_request(OP_RESERVE, OWNER_MAX, 11'd0);
    send_request(OP_RESERVE, 31'd1, 11'd0);
    send_request(OP_RESERVE, 31'h2AAA_AAAA, 11'd0);
    send_request(OP_RESERVE, 31'h5555_5555, 11'd0);
    send_request(OP_RELEASE, 31'd0, 11'd0);
    send_request(OP_RELEASE, 31'd0, 11'd4);
    send_request(OP_RELEASE, 31'd0, 11'd2047);
    send_request(OP_QUERY, 31'd0, 11'd3);
    send_request(OP_RELEASE, 31'd0, 11'd2);
    send_request(OP_RELEASE, 31'd0, 11'd2);
    send_request(OP_QUERY, 31'd0, 11'd2);
    send_request(OP_RESERVE, 31'd9, 11'd0);
    send_request(OP_UNUSED, 31'd7, 11'd5);
    send_request(OP_QUERY, 31'd0, 11'd1);

    // An oversized capacity word saturates to the full table.
    write_capacity(11'd2047);
    send_request(OP_RESERVE, 31'h1234_5678, 11'd0);
    send_request(OP_QUERY, 31'd0, 11'd1024);
    send_request(OP_QUERY, 31'd0, 11'd1025);
    send_request(OP_RELEASE, 31'd0, 11'd1024);
    send_request(OP_QUERY, 31'd0, 11'd1);

    // Random phases. The large one is reserve-heavy so that all 1024 slots
    // fill up and the full case is reached at the top of the map.
    run_phase(11'd1, 60, 50, -1, -1);
    run_phase(11'd2047, 1150, 98, -1, -1);
    run_phase(11'd33, 150, 60, -1, 75);
    run_phase(11'd0, 30, 40, -1, -1);
    run_phase(11'd40, 200, 55, 50, -1);
    run_phase(11'd1024, 100, 50, -1, -1);
    calm = 1'b1;
    run_phase(11'd5, 120, 50, -1, -1);

    wait_drained();
    repeat (DRAIN_PAUSE) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
